@@ hdl/usp_pkg.sv @@
// Package for the unipolar stepper sequencer: field widths, request and
// drive mode codes, and the coil sequence tables.
// Depends on nothing; used by unipolar_stepper_sequencer.
`default_nettype none

package usp_pkg;

  // Default sizes of the angle and timer datapaths.
  localparam int ANGLE_BITS_DEF = 16;
  localparam int TIMER_BITS_DEF = 24;

  // Widths of the beat fields as they travel on the buses.
  localparam int ANGLE_FIELD_BITS  = 16;
  localparam int PERIOD_FIELD_BITS = 24;
  localparam int S_TDATA_BITS      = 48;
  localparam int M_TDATA_BITS      = 8;

  // Kind of an input beat.
  typedef enum logic {
    REQ_MOVE = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  // Drive mode codes. Bit 1 set means half step, so the unused code is half step too.
  localparam logic [1:0] MODE_WAVE = 2'd0;
  localparam logic [1:0] MODE_FULL = 2'd1;
  localparam logic [1:0] MODE_HALF = 2'd2;

  function automatic logic is_half(input logic [1:0] mode);
    return mode[1];
  endfunction

  // Coil pattern for a sequence position: bit0 blue, bit1 pink, bit2 yellow, bit3 orange.
  function automatic logic [3:0] pattern_at(input logic [1:0] mode, input logic [2:0] idx);
    logic [3:0] pat;
    pat = 4'd0;
    if (is_half(mode)) begin
      case (idx)
        3'd0: pat = 4'd1;
        3'd1: pat = 4'd3;
        3'd2: pat = 4'd2;
        3'd3: pat = 4'd6;
        3'd4: pat = 4'd4;
        3'd5: pat = 4'd12;
        3'd6: pat = 4'd8;
        default: pat = 4'd9;
      endcase
    end else if (mode == MODE_FULL) begin
      case (idx[1:0])
        2'd0: pat = 4'd3;
        2'd1: pat = 4'd6;
        2'd2: pat = 4'd12;
        default: pat = 4'd9;
      endcase
    end else begin
      case (idx[1:0])
        2'd0: pat = 4'd1;
        2'd1: pat = 4'd2;
        2'd2: pat = 4'd4;
        default: pat = 4'd8;
      endcase
    end
    return pat;
  endfunction

endpackage

`default_nettype wire

@@ hdl/unipolar_stepper_sequencer.sv @@
// Unipolar stepper sequencer: input beat register, single-pass state update
// and a result register that drives the coil pattern stream.
// Depends on usp_pkg.
// A pattern passes the input beat and result registers. Throughput: one beat per cycle
// unless the result stalls; the step count multiply (angle times a fixed reciprocal of
// 7/40) is the longest path and fits between the input and state registers.
// Reset: synchronous rst clears busy, counters, coil state and both valid flags.
`default_nettype none

module unipolar_stepper_sequencer #(
  parameter int ANGLE_BITS = usp_pkg::ANGLE_BITS_DEF,
  parameter int TIMER_BITS = usp_pkg::TIMER_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Slave side. tdata: angle_deg[15:0], clockwise[16], drive_mode[18:17],
  // step_period[42:19], zeros[47:43]. tuser: req_type.
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [usp_pkg::S_TDATA_BITS-1:0]  s_axis_tdata,
  input  wire logic                              s_axis_tuser,
  // Master side. tdata: coil_pattern[3:0], zeros[7:4]. tlast: last_phase.
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [usp_pkg::M_TDATA_BITS-1:0]       m_axis_tdata,
  output logic                                   m_axis_tlast
);
  import usp_pkg::*;

  // Step count is floor(angle*40/7), computed as angle*RECIP >> RECIP_SHIFT.
  localparam int STEP_BITS   = ANGLE_BITS + 3;
  localparam int RECIP_SHIFT = ANGLE_BITS + 4;
  localparam int RECIP_BITS  = RECIP_SHIFT + 3;
  localparam logic [63:0] RECIP = ((64'd40 << RECIP_SHIFT) + 64'd6) / 64'd7;
  localparam int PROD_BITS   = ANGLE_BITS + RECIP_BITS;

  // Input beat register.
  logic                          in_valid;
  req_t                          in_type;
  logic [ANGLE_FIELD_BITS-1:0]   in_angle;
  logic                          in_cw;
  logic [1:0]                    in_mode;
  logic [PERIOD_FIELD_BITS-1:0]  in_period;

  // Sequencer state.
  logic [3:0]            coil_reg;
  logic [STEP_BITS-1:0]  phases_left;
  logic [2:0]            seq_index;
  logic [TIMER_BITS-1:0] wait_count;
  logic                  busy_flag;
  logic                  dir_reg;
  logic [1:0]            mode_reg;
  logic [TIMER_BITS-1:0] period_reg;

  logic [3:0]            coil_reg_next;
  logic [STEP_BITS-1:0]  phases_left_next;
  logic [2:0]            seq_index_next;
  logic [TIMER_BITS-1:0] wait_count_next;
  logic                  busy_flag_next;
  logic                  dir_reg_next;
  logic [1:0]            mode_reg_next;
  logic [TIMER_BITS-1:0] period_reg_next;

  // Result register.
  logic       res_valid;
  logic [3:0] res_pattern;
  logic       res_last;
  logic       res_load;
  logic [3:0] res_pattern_next;
  logic       res_last_next;

  logic advance;

  // Operand decode of the registered beat.
  logic [31:0]           angle_wide;
  logic [ANGLE_BITS-1:0] angle;
  logic [31:0]           period_wide;
  logic [TIMER_BITS-1:0] period_in;
  logic [TIMER_BITS-1:0] period_load;
  logic [TIMER_BITS-1:0] reload;
  logic [PROD_BITS-1:0]  product;
  logic [STEP_BITS-1:0]  steps;
  logic [STEP_BITS-1:0]  count;
  logic                  zero_move;
  logic [2:0]            step_index;
  logic [2:0]            len_mask;

  // The registered beat moves on when the result register can take a pattern.
  assign advance       = in_valid && (!res_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Capture an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_type   <= req_t'(s_axis_tuser);
      in_angle  <= s_axis_tdata[15:0];
      in_cw     <= s_axis_tdata[16];
      in_mode   <= s_axis_tdata[18:17];
      in_period <= s_axis_tdata[42:19];
    end
  end

  // Operand sizing, step count and phase count.
  always_comb begin
    angle_wide  = {16'd0, in_angle};
    angle       = angle_wide[ANGLE_BITS-1:0];
    period_wide = {8'd0, in_period};
    period_in   = period_wide[TIMER_BITS-1:0];
    period_load = (period_in == '0) ? TIMER_BITS'(1) : period_in;
    reload      = (period_reg == '0) ? TIMER_BITS'(1) : period_reg;
    product     = PROD_BITS'(angle) * PROD_BITS'(RECIP[RECIP_BITS-1:0]);
    steps       = product[RECIP_SHIFT +: STEP_BITS];
    if (is_half(in_mode)) begin
      count = {steps[STEP_BITS-1:3], 3'b000};
    end else begin
      count = {steps[STEP_BITS-1:2], 2'b00};
    end
    // Fewer than one full cycle of patterns: only angle 0, or angle 1 in half step.
    zero_move  = is_half(in_mode) ? (angle <= ANGLE_BITS'(1)) : (angle == '0);
    len_mask   = is_half(mode_reg) ? 3'd7 : 3'd3;
    step_index = dir_reg ? ((seq_index - 3'd1) & len_mask) : ((seq_index + 3'd1) & len_mask);
  end

  // Next state and result for the registered beat.
  always_comb begin
    coil_reg_next    = coil_reg;
    phases_left_next = phases_left;
    seq_index_next   = seq_index;
    wait_count_next  = wait_count;
    busy_flag_next   = busy_flag;
    dir_reg_next     = dir_reg;
    mode_reg_next    = mode_reg;
    period_reg_next  = period_reg;
    res_load         = 1'b0;
    res_pattern_next = pattern_at(mode_reg, seq_index);
    res_last_next    = 1'b0;
    case (in_type)
      REQ_MOVE: begin
        if (!busy_flag) begin
          dir_reg_next    = in_cw;
          mode_reg_next   = in_mode;
          period_reg_next = period_in;
          if (!zero_move) begin
            seq_index_next   = in_cw ? (is_half(in_mode) ? 3'd7 : 3'd3) : 3'd0;
            phases_left_next = count - STEP_BITS'(1);
            wait_count_next  = period_load;
            busy_flag_next   = 1'b1;
            res_load         = 1'b1;
            res_pattern_next = pattern_at(in_mode, seq_index_next);
            // The count is a multiple of four, so the first pattern is never the last.
            res_last_next    = 1'b0;
            coil_reg_next    = res_pattern_next;
          end
        end
      end
      REQ_TICK: begin
        if (busy_flag) begin
          if (wait_count > TIMER_BITS'(1)) begin
            wait_count_next = wait_count - TIMER_BITS'(1);
          end else if (phases_left == '0) begin
            // Final wait is over: go idle with the coils held.
            wait_count_next = '0;
            busy_flag_next  = 1'b0;
          end else begin
            phases_left_next = phases_left - STEP_BITS'(1);
            seq_index_next   = step_index;
            wait_count_next  = reload;
            res_load         = 1'b1;
            res_pattern_next = pattern_at(mode_reg, step_index);
            res_last_next    = (phases_left == STEP_BITS'(1));
            coil_reg_next    = res_pattern_next;
          end
        end
      end
      default: begin
        res_load = 1'b0;
      end
    endcase
  end

  // Sequencer state update.
  always_ff @(posedge clk) begin
    if (rst) begin
      coil_reg    <= '0;
      phases_left <= '0;
      seq_index   <= '0;
      wait_count  <= '0;
      busy_flag   <= 1'b0;
      dir_reg     <= 1'b0;
      mode_reg    <= MODE_WAVE;
      period_reg  <= '0;
    end else if (advance) begin
      coil_reg    <= coil_reg_next;
      phases_left <= phases_left_next;
      seq_index   <= seq_index_next;
      wait_count  <= wait_count_next;
      busy_flag   <= busy_flag_next;
      dir_reg     <= dir_reg_next;
      mode_reg    <= mode_reg_next;
      period_reg  <= period_reg_next;
    end
  end

  // Result register: loaded by a pattern, emptied when the master side takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance && res_load) begin
      res_valid <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid <= 1'b0;
    end
    if (advance && res_load) begin
      res_pattern <= res_pattern_next;
      res_last    <= res_last_next;
    end
  end

  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = {4'd0, res_pattern};
  assign m_axis_tlast  = res_last;

  // While a move runs there is always a wait in progress.
  a_busy_wait : assert property (@(posedge clk) disable iff (rst)
    busy_flag |-> (wait_count != '0))
    else $error("busy with no wait in progress");

  // The block only goes idle after the last pattern has been sent.
  a_idle_done : assert property (@(posedge clk) disable iff (rst)
    $fell(busy_flag) |-> ($past(phases_left) == '0))
    else $error("went idle with patterns left");

  // Every emitted pattern belongs to a running move.
  a_emit_busy : assert property (@(posedge clk) disable iff (rst)
    (advance && res_load) |=> busy_flag)
    else $error("pattern emitted while idle");

  // Input back-pressure comes only from a stalled result.
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without output back-pressure");

endmodule

`default_nettype wire
